// File: design/das_pkg.sv
`default_nettype none
package das_pkg;

  // input item kinds
  localparam logic [2:0] KIND_TICK      = 3'd0;
  localparam logic [2:0] KIND_BEGIN     = 3'd1;
  localparam logic [2:0] KIND_TERMINATE = 3'd2;
  localparam logic [2:0] KIND_DISCOVER  = 3'd3;
  localparam logic [2:0] KIND_GM_CHANGE = 3'd4;
  localparam logic [2:0] KIND_LINK_UP   = 3'd5;
  localparam logic [2:0] KIND_LINK_DOWN = 3'd6;

  localparam logic MSG_AVAILABLE = 1'b0;
  localparam logic MSG_DEPARTING = 1'b1;

  localparam int MASK_W   = 4;
  localparam int DRAW_W   = 16;
  localparam int TIMER_W  = 14;
  localparam int VT_W     = 6;
  localparam int SECS_W   = 4;
  localparam int ITER_W   = $clog2(DRAW_W);

  localparam logic [VT_W-1:0]    VALID_TIME_RST = 6'd62;
  localparam logic [TIMER_W-1:0] DELAY_MIN_MS   = 14'd100;
  localparam logic [TIMER_W-1:0] MS_PER_S       = 14'd1000;
  // x/5 for x < 64 is (x*13) >> 6
  localparam int DIV5_MUL = 13;
  localparam int DIV5_SH  = 6;
  localparam int DIV4_SH  = 2;

  typedef enum logic [1:0] {
    ENT_NOT_STARTED = 2'd0,
    ENT_DELAY       = 2'd1,
    ENT_WAITING     = 2'd2
  } ent_phase_t;

  typedef enum logic [1:0] {
    PH_NOT_STARTED = 2'd0,
    PH_WAITING     = 2'd1,
    PH_LINK_DOWN   = 2'd2
  } port_phase_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [1:0]        port;
    logic [MASK_W-1:0] port_up_mask;
    logic [DRAW_W-1:0] random_draw;
    logic              ready_req;
  } in_item_t;

  typedef struct packed {
    logic        message_type;
    logic [1:0]  out_port;
    logic [31:0] avail_index;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic mod_start;
    logic load_delay;
    logic emit;
  } das_cmd_t;

  typedef struct packed {
    logic need_arm;
    logic mod_done;
    logic emit_any;
    logic slot_free;
  } das_sts_t;

endpackage
`default_nettype wire

// File: design/discovery_advertise_sequencer_core.sv
`default_nettype none
// channel   ports                               item
// input     in_valid, in_ready, in_data         in_item_t: event or one ms tick
// result    out_valid, out_ready, out_data      out_item_t: one advertise message
// config    cfg_we, cfg_wdata                   validity time in seconds
//
// an item that arms no delay and sends nothing passes through the idle, exec and emit states
// arming the random delay adds the arm state: a 16-step remainder unit, one bit a cycle
// each message is one emit in the emit state, held while the output register is full and out_ready is low
// reset is synchronous: entity and ports not started, index and timers zero
// the next item is taken while the last message still waits in the output register
module discovery_advertise_sequencer_core #(
  parameter int NUM_PORTS = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire das_pkg::in_item_t       in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output das_pkg::out_item_t           out_data,
  input  wire                          cfg_we,
  input  wire [das_pkg::VT_W-1:0]      cfg_wdata
);
  import das_pkg::*;

  das_cmd_t cmd;
  das_sts_t sts;

  das_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  das_dp #(
    .NUM_PORTS (NUM_PORTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

// File: design/das_mod.sv
`default_nettype none
module das_mod (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  input  wire [das_pkg::DRAW_W-1:0]          dividend,
  input  wire [das_pkg::TIMER_W-1:0]         divisor,
  output logic                               done,
  output logic [das_pkg::TIMER_W-1:0]        remainder
);
  import das_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [ITER_W-1:0]   cnt_r;
  logic [TIMER_W-1:0]  rem_r;
  logic [TIMER_W-1:0]  rem_nxt;
  logic [DRAW_W-1:0]   q_r;
  logic [TIMER_W-1:0]  div_r;
  logic [TIMER_W:0]    trial;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, q_r[DRAW_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = TIMER_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = trial[TIMER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(DRAW_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_r << 1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: design/das_dp.sv
`default_nettype none
module das_dp #(
  parameter int NUM_PORTS = 4
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire das_pkg::das_cmd_t      cmd,
  output das_pkg::das_sts_t           sts,
  input  wire das_pkg::in_item_t      in_data,
  input  wire                         out_ready,
  output logic                        out_valid,
  output das_pkg::out_item_t          out_data,
  input  wire                         cfg_we,
  input  wire [das_pkg::VT_W-1:0]     cfg_wdata
);
  import das_pkg::*;

  logic [VT_W-1:0]     vt_r;
  in_item_t            item_r;
  ent_phase_t          ent_r, ent_nxt;
  port_phase_t         ph_r   [NUM_PORTS];
  port_phase_t         ph_nxt [NUM_PORTS];
  logic [31:0]         count_r, count_nxt;
  logic [TIMER_W-1:0]  dly_r, dly_nxt;
  logic [TIMER_W-1:0]  rea_r, rea_nxt;
  logic [NUM_PORTS-1:0] emask_r, emask_nxt;
  logic                etype_r, etype_nxt;
  logic [31:0]         eidx_r, eidx_nxt;
  logic                out_valid_r;
  out_item_t           out_r;

  logic                arm;
  logic                adv;
  logic                dexp, rexp;
  logic                port_ok;
  port_phase_t         sel_ph;
  logic [NUM_PORTS-1:0] wait_v;
  logic [NUM_PORTS+MASK_W-1:0] mask_ext;

  logic [9:0]          prod5;
  logic [SECS_W-1:0]   secs_d, secs_r;
  logic [TIMER_W-1:0]  max_delay;
  logic [TIMER_W-1:0]  mod_div;
  logic [TIMER_W-1:0]  rea_period;
  logic                mod_done;
  logic [TIMER_W-1:0]  mod_rem;

  logic                found;
  logic [1:0]          pick_port;
  logic [NUM_PORTS-1:0] pick_clr;
  logic                slot_free;

  // periods from the validity time
  always_comb begin
    prod5  = 10'(vt_r) * 10'(DIV5_MUL);
    secs_d = SECS_W'(prod5 >> DIV5_SH);
    if (secs_d == '0) secs_d = SECS_W'(1);
    secs_r = SECS_W'(vt_r >> DIV4_SH);
    if (secs_r == '0) secs_r = SECS_W'(1);
    max_delay  = TIMER_W'(secs_d) * MS_PER_S;
    mod_div    = max_delay - DELAY_MIN_MS + TIMER_W'(1);
    rea_period = TIMER_W'(secs_r) * MS_PER_S;
  end

  das_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (item_r.random_draw),
    .divisor   (mod_div),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // one step of both machines on the captured item
  always_comb begin
    ent_nxt   = ent_r;
    count_nxt = count_r;
    dly_nxt   = dly_r;
    rea_nxt   = rea_r;
    emask_nxt = '0;
    etype_nxt = MSG_AVAILABLE;
    eidx_nxt  = count_r;
    arm       = 1'b0;
    adv       = 1'b0;
    dexp      = 1'b0;
    rexp      = 1'b0;
    port_ok   = 1'b0;
    sel_ph    = PH_NOT_STARTED;
    mask_ext  = {{NUM_PORTS{1'b0}}, item_r.port_up_mask};
    for (int p = 0; p < NUM_PORTS; p++) begin
      ph_nxt[p] = ph_r[p];
      wait_v[p] = (ph_r[p] == PH_WAITING);
      if (p == int'(item_r.port)) begin
        port_ok = 1'b1;
        sel_ph  = ph_r[p];
      end
    end

    unique case (item_r.kind)
      KIND_TICK: begin
        if (dly_r != '0) begin
          dly_nxt = dly_r - 1'b1;
          dexp    = (dly_r == TIMER_W'(1));
        end
        if (rea_r != '0) begin
          rea_nxt = rea_r - 1'b1;
          rexp    = (rea_r == TIMER_W'(1));
        end
        if (dexp && item_r.ready_req && ent_r == ENT_DELAY) begin
          emask_nxt = wait_v;
          rea_nxt   = rea_period;
          ent_nxt   = ENT_WAITING;
        end
        // reannounce sees the phase left by the delay expiry
        if (rexp && item_r.ready_req && ent_nxt == ENT_WAITING) begin
          count_nxt = count_r + 1'b1;
          arm       = 1'b1;
          ent_nxt   = ENT_DELAY;
        end
      end
      KIND_BEGIN: begin
        if (ent_r == ENT_NOT_STARTED) begin
          count_nxt = '0;
          for (int p = 0; p < NUM_PORTS; p++) begin
            if (ph_r[p] == PH_NOT_STARTED) begin
              ph_nxt[p] = mask_ext[p] ? PH_WAITING : PH_LINK_DOWN;
            end
          end
          arm     = 1'b1;
          ent_nxt = ENT_DELAY;
        end
      end
      KIND_TERMINATE: begin
        if (item_r.ready_req) begin
          if (ent_r == ENT_DELAY) begin
            dly_nxt = '0;
            ent_nxt = ENT_NOT_STARTED;
          end else if (ent_r == ENT_WAITING) begin
            rea_nxt   = '0;
            count_nxt = '0;
            emask_nxt = wait_v;
            etype_nxt = MSG_DEPARTING;
            eidx_nxt  = '0;
            for (int p = 0; p < NUM_PORTS; p++) begin
              if (wait_v[p]) ph_nxt[p] = PH_NOT_STARTED;
            end
            ent_nxt = ENT_NOT_STARTED;
          end
        end
      end
      KIND_DISCOVER, KIND_GM_CHANGE: begin
        adv = port_ok && sel_ph == PH_WAITING;
      end
      KIND_LINK_UP: begin
        if (port_ok && sel_ph == PH_LINK_DOWN) begin
          adv = 1'b1;
          for (int p = 0; p < NUM_PORTS; p++) begin
            if (p == int'(item_r.port)) ph_nxt[p] = PH_WAITING;
          end
        end
      end
      KIND_LINK_DOWN: begin
        if (port_ok && sel_ph == PH_WAITING) begin
          for (int p = 0; p < NUM_PORTS; p++) begin
            if (p == int'(item_r.port)) ph_nxt[p] = PH_LINK_DOWN;
          end
        end
      end
      default: begin
      end
    endcase

    if (adv && ent_r == ENT_WAITING) begin
      rea_nxt   = '0;
      count_nxt = count_r + 1'b1;
      arm       = 1'b1;
      ent_nxt   = ENT_DELAY;
    end
  end

  // lowest pending port goes out first
  always_comb begin
    found     = 1'b0;
    pick_port = '0;
    pick_clr  = '0;
    for (int p = 0; p < NUM_PORTS; p++) begin
      if (!found && emask_r[p]) begin
        found       = 1'b1;
        pick_port   = 2'(p);
        pick_clr[p] = 1'b1;
      end
    end
  end

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt_r        <= VALID_TIME_RST;
      ent_r       <= ENT_NOT_STARTED;
      for (int p = 0; p < NUM_PORTS; p++) ph_r[p] <= PH_NOT_STARTED;
      count_r     <= '0;
      dly_r       <= '0;
      rea_r       <= '0;
      emask_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) vt_r <= cfg_wdata;
      if (cmd.exec) begin
        ent_r   <= ent_nxt;
        for (int p = 0; p < NUM_PORTS; p++) ph_r[p] <= ph_nxt[p];
        count_r <= count_nxt;
        dly_r   <= dly_nxt;
        rea_r   <= rea_nxt;
        emask_r <= emask_nxt;
      end else if (cmd.emit) begin
        emask_r <= emask_r & ~pick_clr;
      end
      if (cmd.load_delay) dly_r <= DELAY_MIN_MS + mod_rem;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.exec) begin
      etype_r <= etype_nxt;
      eidx_r  <= eidx_nxt;
    end
    if (cmd.emit) begin
      out_r.message_type <= etype_r;
      out_r.out_port     <= pick_port;
      out_r.avail_index  <= eidx_r;
      out_r.last         <= ((emask_r & ~pick_clr) == '0);
    end
  end

  assign sts.need_arm  = arm;
  assign sts.mod_done  = mod_done;
  assign sts.emit_any  = |emask_r;
  assign sts.slot_free = slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: design/das_ctrl.sv
`default_nettype none
module das_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output das_pkg::das_cmd_t       cmd,
  input  wire das_pkg::das_sts_t  sts
);
  import das_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_ARM  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.need_arm) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ST_ARM;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_ARM: begin
        if (sts.mod_done) begin
          cmd.load_delay = 1'b1;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!sts.emit_any) begin
          state_nxt = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire
